/* src/afp_pkg.sv */
// Package for the angle frame parser: configuration indexes, reset values,
// frame constants, the parse phase type and the structs passed between modules.
// No dependencies.
`default_nettype none

package afp_pkg;

    localparam int unsigned CfgIndexWidth = 2;

    localparam logic [CfgIndexWidth-1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_SYNC_SECOND = 2'd1;
    localparam logic [CfgIndexWidth-1:0] CFG_FRAME_TYPE  = 2'd2;

    localparam logic [7:0] SYNC_FIRST_RESET  = 8'hEB;
    localparam logic [7:0] SYNC_SECOND_RESET = 8'h90;
    localparam logic [7:0] FRAME_TYPE_RESET  = 8'h25;

    localparam logic [4:0] WORD_BYTES   = 5'd4;
    localparam logic [4:0] PAYLOAD_SKIP = 5'd24;

    typedef enum logic [7:0] {
        PH_SYNC1    = 8'b0000_0001,
        PH_SYNC2    = 8'b0000_0010,
        PH_TYPE     = 8'b0000_0100,
        PH_FREE     = 8'b0000_1000,
        PH_ATTACK   = 8'b0001_0000,
        PH_SIDESLIP = 8'b0010_0000,
        PH_PAYLOAD  = 8'b0100_0000,
        PH_CHECK    = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic [7:0] sync_first;
        logic [7:0] sync_second;
        logic [7:0] frame_type;
    } cfg_t;

    typedef struct packed {
        logic        hit;
        logic        at_check;
        logic [4:0]  byte_count;
        logic [31:0] attack;
        logic [31:0] sideslip;
    } parse_res_t;

endpackage

`default_nettype wire

/* src/afp_cfg_regs.sv */
// Configuration registers of the angle frame parser: sync bytes and frame type.
// Depends on afp_pkg.
`default_nettype none

module afp_cfg_regs
    import afp_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_wr_en,
    input  wire logic [CfgIndexWidth-1:0] cfg_index,
    input  wire logic [7:0]               cfg_wr_data,
    output cfg_t                          cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_SYNC_FIRST:  cfg_next.sync_first  = cfg_wr_data;
                CFG_SYNC_SECOND: cfg_next.sync_second = cfg_wr_data;
                CFG_FRAME_TYPE:  cfg_next.frame_type  = cfg_wr_data;
                default:         cfg_next = cfg_reg;  // drop writes past the list
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_first  <= SYNC_FIRST_RESET;
            cfg_reg.sync_second <= SYNC_SECOND_RESET;
            cfg_reg.frame_type  <= FRAME_TYPE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* src/afp_parser.sv */
// Frame hunting state machine: phase, running sum, byte count, word shifters.
// Flags a good checksum on the accepted beat. Depends on afp_pkg.
`default_nettype none

module afp_parser
    import afp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] rx_byte,
    input  wire cfg_t       cfg,
    output parse_res_t      res
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  sum_reg, sum_next;
    logic [4:0]  count_reg, count_next;
    logic [31:0] attack_reg, attack_next;
    logic [31:0] sideslip_reg, sideslip_next;
    logic [4:0]  count_inc;
    logic [7:0]  sum_add;
    logic        hit;

    assign count_inc = count_reg + 5'd1;
    assign sum_add   = sum_reg + rx_byte;

    always_comb
    begin
        phase_next    = phase_reg;
        sum_next      = sum_reg;
        count_next    = count_reg;
        attack_next   = attack_reg;
        sideslip_next = sideslip_reg;
        hit           = 1'b0;
        if (accept)
        begin
            case (phase_reg)
                PH_SYNC1, PH_SYNC2, PH_TYPE:
                begin
                    // mismatch drops the hunt; this beat is not retried as first sync
                    if ((phase_reg == PH_SYNC1 && rx_byte == cfg.sync_first)
                        || (phase_reg == PH_SYNC2 && rx_byte == cfg.sync_second)
                        || (phase_reg == PH_TYPE && rx_byte == cfg.frame_type))
                    begin
                        sum_next   = sum_add;
                        phase_next = (phase_reg == PH_SYNC1) ? PH_SYNC2 :
                                     (phase_reg == PH_SYNC2) ? PH_TYPE : PH_FREE;
                    end
                    else
                    begin
                        sum_next   = 8'd0;
                        phase_next = PH_SYNC1;
                    end
                end
                PH_FREE:
                begin
                    sum_next   = sum_add;
                    count_next = 5'd0;
                    phase_next = PH_ATTACK;
                end
                PH_ATTACK:
                begin
                    sum_next    = sum_add;
                    attack_next = {attack_reg[23:0], rx_byte};
                    count_next  = count_inc;
                    if (count_inc >= WORD_BYTES)
                    begin
                        count_next = 5'd0;
                        phase_next = PH_SIDESLIP;
                    end
                end
                PH_SIDESLIP:
                begin
                    sum_next      = sum_add;
                    sideslip_next = {sideslip_reg[23:0], rx_byte};
                    count_next    = count_inc;
                    if (count_inc >= WORD_BYTES)
                    begin
                        count_next = 5'd0;
                        phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    sum_next   = sum_add;
                    count_next = count_inc;
                    if (count_inc >= PAYLOAD_SKIP)
                    begin
                        count_next = 5'd0;
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK:
                begin
                    hit        = (sum_reg == rx_byte);
                    sum_next   = 8'd0;
                    phase_next = PH_SYNC1;
                end
                default:
                begin
                    sum_next   = 8'd0;
                    phase_next = PH_SYNC1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SYNC1;
            sum_reg      <= 8'd0;
            count_reg    <= 5'd0;
            attack_reg   <= 32'd0;
            sideslip_reg <= 32'd0;
        end
        else
        begin
            phase_reg    <= phase_next;
            sum_reg      <= sum_next;
            count_reg    <= count_next;
            attack_reg   <= attack_next;
            sideslip_reg <= sideslip_next;
        end
    end

    assign res.hit        = hit;
    assign res.at_check   = (phase_reg == PH_CHECK);
    assign res.byte_count = count_reg;
    assign res.attack     = attack_reg;
    assign res.sideslip   = sideslip_reg;

endmodule

`default_nettype wire

/* src/afp_out_reg.sv */
// Result register of the angle frame parser: holds one decoded frame until taken.
// Depends on afp_pkg.
`default_nettype none

module afp_out_reg
    import afp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire parse_res_t  res,
    input  wire logic        out_stall,
    output logic             out_valid,
    output logic [31:0]      attack_bits,
    output logic [31:0]      sideslip_bits
);

    logic        valid_reg, valid_next;
    logic [31:0] attack_reg;
    logic [31:0] sideslip_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (res.hit)
            valid_next = 1'b1;
        else if (!out_stall)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // payload loads only on a good frame; upstream never hits while a beat is stuck
    always_ff @(posedge clk)
    begin
        if (res.hit)
        begin
            attack_reg   <= res.attack;
            sideslip_reg <= res.sideslip;
        end
    end

    assign out_valid     = valid_reg;
    assign attack_bits   = attack_reg;
    assign sideslip_bits = sideslip_reg;

endmodule

`default_nettype wire

/* src/angle_frame_parser.sv */
// Channel   | handshake            | payload
// ----------+----------------------+------------------------------------------
// input     | in_valid / in_stall  | rx_byte[7:0]
// output    | out_valid / out_stall| attack_bits[31:0], sideslip_bits[31:0]
// config    | cfg_wr_en            | cfg_index[1:0], cfg_wr_data[7:0]
//
// One byte per cycle is taken while in_stall is low; the state update is a single registered step.
// A good checksum shows its result on the outputs in the cycle after the checksum byte.
// The result register is the only buffer: only the checksum byte waits on it,
// all other bytes flow while a result sits stalled.
// Reset (rst_n, async, active low) sets the hunt to the first sync byte, the
// sum and count to zero, and the sync/type registers to EB, 90, 25 hex.
// Depends on afp_pkg, afp_cfg_regs, afp_parser, afp_out_reg.
`default_nettype none

module angle_frame_parser
    import afp_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [7:0]               rx_byte,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic [31:0]                   attack_bits,
    output logic [31:0]                   sideslip_bits,
    input  wire logic                     cfg_wr_en,
    input  wire logic [CfgIndexWidth-1:0] cfg_index,
    input  wire logic [7:0]               cfg_wr_data
);

    cfg_t       cfg;
    parse_res_t res;
    logic       accept;

    // hold the checksum beat while the previous result is stuck
    assign in_stall = res.at_check && out_valid && out_stall;
    assign accept   = in_valid && !in_stall;

    afp_cfg_regs u_cfg
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    afp_parser u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (rx_byte),
        .cfg     (cfg),
        .res     (res)
    );

    afp_out_reg u_out
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .res           (res),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .attack_bits   (attack_bits),
        .sideslip_bits (sideslip_bits)
    );

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res.hit |-> !(out_valid && out_stall))
        else $error("result produced while output register is stalled");

    a_result_from_beat: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(accept && res.at_check))
        else $error("result appeared without an accepted checksum beat");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res.byte_count < PAYLOAD_SKIP)
        else $error("byte count ran past the payload length");

endmodule

`default_nettype wire

/* test/angle_frame_parser_test.sv */
// Testbench for angle_frame_parser: directed frame table, then random frames, noise
// and broken headers under several sync/type settings, all checked against a local parser.
// Depends on afp_pkg and the angle_frame_parser RTL.
`timescale 1ns / 100ps

module angle_frame_parser_test;
    import afp_pkg::*;

    localparam int unsigned HALF_PERIOD = 5;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned HOLD_CYCLES = 600;
    localparam int unsigned IDLE_TAIL = 4;
    localparam int unsigned PHASE_BYTES = 260;
    localparam int unsigned SETTING_COUNT = 6;
    localparam int unsigned PLAN_ROWS = 10;
    localparam logic [CfgIndexWidth-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [31:0] attack;
        logic [31:0] sideslip;
    } angle_pair_t;

    // One directed frame; typed rows carry their own expected result.
    typedef struct packed {
        logic [7:0]  s1;
        logic [7:0]  s2;
        logic [7:0]  ty;
        logic [1:0]  hlen;
        logic        body;
        logic [7:0]  spare;
        logic [31:0] atk;
        logic [31:0] sds;
        logic [7:0]  fill;
        logic        sum_ok;
        logic        typed;
        logic        exp_hit;
    } frame_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [7:0]               rx_byte;
    logic                     out_valid;
    logic                     out_stall;
    logic [31:0]              attack_bits;
    logic [31:0]              sideslip_bits;
    logic                     cfg_wr_en;
    logic [CfgIndexWidth-1:0] cfg_index;
    logic [7:0]               cfg_wr_data;

    // local copy of the parser
    cfg_t        regs_copy;
    phase_t      parse_at;
    logic [7:0]  frame_sum;
    logic [4:0]  word_count;
    logic [31:0] attack_acc;
    logic [31:0] sideslip_acc;

    angle_pair_t angles_due [$];
    angle_pair_t due_head;
    frame_row_t  plan [PLAN_ROWS];

    logic        typed_row = 1'b0;
    logic        calm = 1'b0;
    logic        hold_req = 1'b0;
    int unsigned bytes_fed = 0;
    int unsigned frames_predicted = 0;
    int unsigned frames_checked = 0;
    int unsigned settings_used = 0;
    int unsigned errors = 0;
    int unsigned cycles = 0;

    angle_frame_parser u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .attack_bits   (attack_bits),
        .sideslip_bits (sideslip_bits),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data)
    );

    always #(HALF_PERIOD) clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    task automatic advance_parser(input logic [7:0] b, output logic hit,
                                  output angle_pair_t res);
        logic [7:0] want;
        hit = 1'b0;
        res = '{attack_acc, sideslip_acc};
        case (parse_at)
            PH_SYNC1, PH_SYNC2, PH_TYPE:
            begin
                want = (parse_at == PH_SYNC1) ? regs_copy.sync_first :
                       (parse_at == PH_SYNC2) ? regs_copy.sync_second :
                                                regs_copy.frame_type;
                if (b == want)
                begin
                    frame_sum = frame_sum + b;
                    parse_at = phase_t'(parse_at << 1);
                end
                else
                begin
                    // drop back to the hunt; this byte is not tried again
                    parse_at = PH_SYNC1;
                    frame_sum = '0;
                end
            end
            PH_FREE:
            begin
                frame_sum = frame_sum + b;
                word_count = '0;
                parse_at = PH_ATTACK;
            end
            PH_ATTACK:
            begin
                frame_sum = frame_sum + b;
                attack_acc = {attack_acc[23:0], b};
                word_count = word_count + 5'd1;
                if (word_count >= WORD_BYTES)
                begin
                    word_count = '0;
                    parse_at = PH_SIDESLIP;
                end
            end
            PH_SIDESLIP:
            begin
                frame_sum = frame_sum + b;
                sideslip_acc = {sideslip_acc[23:0], b};
                word_count = word_count + 5'd1;
                if (word_count >= WORD_BYTES)
                begin
                    word_count = '0;
                    parse_at = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                frame_sum = frame_sum + b;
                word_count = word_count + 5'd1;
                if (word_count >= PAYLOAD_SKIP)
                begin
                    word_count = '0;
                    parse_at = PH_CHECK;
                end
            end
            default:
            begin
                // checksum byte is compared, never added
                hit = (frame_sum == b);
                parse_at = PH_SYNC1;
                frame_sum = '0;
            end
        endcase
    endtask

    task automatic feed_byte(input logic [7:0] b);
        int unsigned gap;
        logic hit;
        angle_pair_t res;
        gap = calm ? 0 : pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        advance_parser(b, hit, res);
        if (hit)
            frames_predicted++;
        if (hit && !typed_row)
            angles_due.push_back(res);
        in_valid <= 1'b1;
        rx_byte <= b;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        bytes_fed++;
    endtask

    task automatic emit_frame(input frame_row_t r, input logic rand_fill);
        logic [7:0] seq [0:63];
        logic [7:0] sum;
        int n;
        seq[0] = r.s1;
        seq[1] = r.s2;
        seq[2] = r.ty;
        n = r.hlen;
        if (r.body)
        begin
            seq[3] = r.spare;
            for (int k = 0; k < 4; k++)
            begin
                seq[4 + k] = r.atk[31 - 8*k -: 8];
                seq[8 + k] = r.sds[31 - 8*k -: 8];
            end
            for (int k = 0; k < PAYLOAD_SKIP; k++)
                seq[12 + k] = rand_fill ? 8'($urandom) : r.fill;
            n = 12 + PAYLOAD_SKIP;
            sum = '0;
            for (int k = 0; k < n; k++)
                sum = sum + seq[k];
            seq[n] = r.sum_ok ? sum : sum ^ 8'($urandom_range(255, 1));
            n++;
        end
        typed_row = r.typed;
        for (int k = 0; k < n; k++)
        begin
            if (r.typed && r.exp_hit && k == n - 1)
                angles_due.push_back('{r.atk, r.sds});
            feed_byte(seq[k]);
        end
        typed_row = 1'b0;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (angles_due.size() != 0)
            @(negedge clk);
        repeat (IDLE_TAIL) @(negedge clk);
    endtask

    task automatic load_regs(input cfg_t c);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_SYNC_FIRST;
        cfg_wr_data <= c.sync_first;
        @(negedge clk);
        cfg_index <= CFG_SYNC_SECOND;
        cfg_wr_data <= c.sync_second;
        @(negedge clk);
        cfg_index <= CFG_FRAME_TYPE;
        cfg_wr_data <= c.frame_type;
        @(negedge clk);
        // unused index must be ignored
        cfg_index <= CFG_SPARE;
        cfg_wr_data <= 8'($urandom);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        regs_copy = c;
        settings_used++;
    endtask

    // receiver: random stalls, plus one long hold on request
    initial
    begin : drain
        int unsigned left;
        logic hold_taken;
        left = 0;
        hold_taken = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                left = HOLD_CYCLES;
            end
            if (left != 0)
            begin
                out_stall <= 1'b1;
                left--;
            end
            else if (calm || $urandom_range(3) != 0)
                out_stall <= 1'b0;
            else
            begin
                left = pick_gap();
                out_stall <= (left != 0);
                if (left != 0)
                    left--;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (angles_due.size() == 0)
            begin
                $error("unexpected beat: attack_bits %h sideslip_bits %h",
                       attack_bits, sideslip_bits);
                errors++;
            end
            else
            begin
                due_head = angles_due.pop_front();
                if (attack_bits !== due_head.attack)
                begin
                    $error("attack_bits: expected %h, got %h", due_head.attack, attack_bits);
                    errors++;
                end
                if (sideslip_bits !== due_head.sideslip)
                begin
                    $error("sideslip_bits: expected %h, got %h",
                           due_head.sideslip, sideslip_bits);
                    errors++;
                end
                frames_checked++;
            end
        end
    end

    initial
    begin : stimulus
        cfg_t setting;
        frame_row_t r;
        int unsigned goal;
        int unsigned roll;
        int unsigned k;
        rst_n = 1'b0;
        in_valid = 1'b0;
        rx_byte = '0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_SYNC_FIRST;
        cfg_wr_data = '0;
        regs_copy = '{SYNC_FIRST_RESET, SYNC_SECOND_RESET, FRAME_TYPE_RESET};
        parse_at = PH_SYNC1;
        frame_sum = '0;
        word_count = '0;
        attack_acc = '0;
        sideslip_acc = '0;

        //        s1     s2     ty     hlen  body  spare  atk           sds
        //        fill   ok    typed  hit
        plan = '{
            '{8'h00, 8'h90, 8'h25, 2'd1, 1'b0, 8'h00, 32'h00000000, 32'h00000000,
              8'h00, 1'b1, 1'b1, 1'b0},
            '{8'hEB, 8'h00, 8'h25, 2'd2, 1'b0, 8'h00, 32'h00000000, 32'h00000000,
              8'h00, 1'b1, 1'b1, 1'b0},
            '{8'hEB, 8'h90, 8'hFF, 2'd3, 1'b0, 8'h00, 32'h00000000, 32'h00000000,
              8'h00, 1'b1, 1'b1, 1'b0},
            '{8'hEB, 8'h90, 8'h25, 2'd3, 1'b1, 8'h00, 32'h00000000, 32'h00000000,
              8'h00, 1'b1, 1'b1, 1'b1},
            '{8'hEB, 8'h90, 8'h25, 2'd3, 1'b1, 8'hFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
              8'hFF, 1'b1, 1'b1, 1'b1},
            '{8'hEB, 8'h90, 8'h25, 2'd3, 1'b1, 8'h5A, 32'h3F800000, 32'hBF800000,
              8'hA5, 1'b1, 1'b1, 1'b1},
            '{8'hEB, 8'h90, 8'h25, 2'd3, 1'b1, 8'h00, 32'h12345678, 32'h9ABCDEF0,
              8'h00, 1'b0, 1'b1, 1'b0},
            // lone first sync: the next frame's first byte must not restart the hunt
            '{8'hEB, 8'h90, 8'h25, 2'd1, 1'b0, 8'h00, 32'h00000000, 32'h00000000,
              8'h00, 1'b1, 1'b1, 1'b0},
            '{8'hEB, 8'h90, 8'h25, 2'd3, 1'b1, 8'h44, 32'h01020304, 32'h05060708,
              8'h33, 1'b1, 1'b0, 1'b0},
            '{8'hEB, 8'h90, 8'h25, 2'd3, 1'b1, 8'h00, 32'h80000000, 32'h7F7FFFFF,
              8'h00, 1'b1, 1'b0, 1'b0}
        };

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < PLAN_ROWS; i++)
            emit_frame(plan[i], 1'b0);

        for (int p = 0; p < SETTING_COUNT; p++)
        begin
            wait_idle();
            case (p)
                0: setting = '{8'h00, 8'h00, 8'h00};
                1: setting = '{8'hFF, 8'hFF, 8'hFF};
                2: setting = '{8'h00, 8'hFF, 8'h80};
                4: setting = '{SYNC_FIRST_RESET, SYNC_SECOND_RESET, FRAME_TYPE_RESET};
                default: setting = cfg_t'($urandom);
            endcase
            load_regs(setting);
            calm = (p == 3);
            if (p == 1)
                hold_req = 1'b1;
            goal = bytes_fed + PHASE_BYTES;
            while (bytes_fed < goal || frames_predicted < 5 * (p + 1))
            begin
                roll = $urandom_range(99);
                r.s1 = regs_copy.sync_first;
                r.s2 = regs_copy.sync_second;
                r.ty = regs_copy.frame_type;
                r.hlen = 2'd3;
                r.body = 1'b1;
                r.spare = 8'($urandom);
                r.atk = $urandom;
                r.sds = $urandom;
                r.fill = '0;
                r.sum_ok = ($urandom_range(99) < 85);
                r.typed = 1'b0;
                r.exp_hit = 1'b0;
                if (roll < 80)
                    emit_frame(r, 1'b1);
                else if (roll < 90)
                begin
                    // corrupt one header byte and cut the frame there
                    k = $urandom_range(2);
                    case (k)
                        0: r.s1 = r.s1 ^ 8'($urandom_range(255, 1));
                        1: r.s2 = r.s2 ^ 8'($urandom_range(255, 1));
                        default: r.ty = r.ty ^ 8'($urandom_range(255, 1));
                    endcase
                    r.hlen = 2'(k + 1);
                    r.body = 1'b0;
                    emit_frame(r, 1'b1);
                end
                else
                    repeat ($urandom_range(6, 1)) feed_byte(8'($urandom));
            end
        end

        calm = 1'b0;
        wait_idle();
        $display("Fed %0d bytes under %0d register settings: directed frames, bad sums,",
                 bytes_fed, settings_used + 1);
        $display("header faults, line noise and a long output hold; %0d frames compared.",
                 frames_checked);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
